/* design/cgsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cgsm_pkg;

  // Slot numbers are three bits wide: the display offers at most eight slots
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned GLYPH_W = 6;

  // Operation codes on the input channel
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Kind of the item held between decode and commit
  localparam logic [1:0] KIND_ASCII = 2'd0;
  localparam logic [1:0] KIND_GLYPH = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // Decoded map value: bit 7 set marks a custom glyph number in bits 5:0,
  // otherwise the byte is the ASCII look-alike; zero marks an unknown code
  localparam logic [7:0] MAP_UNKNOWN = 8'h00;
  localparam logic [7:0] MAP_GLYPH   = 8'h80;

  // Priority match token handed from cell to cell
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } cgsm_chain_t;

  function automatic logic [7:0] cgsm_decode(input logic [15:0] code);
    logic [7:0] v;
    case (code)
      16'hd0b0: v = "a";
      16'hd0b1: v = MAP_GLYPH | 8'd0;
      16'hd0b2: v = MAP_GLYPH | 8'd1;
      16'hd0b3: v = MAP_GLYPH | 8'd2;
      16'hd0b4: v = MAP_GLYPH | 8'd3;
      16'hd0b5: v = "e";
      16'hd191: v = MAP_GLYPH | 8'd4;
      16'hd0b6: v = MAP_GLYPH | 8'd5;
      16'hd0b7: v = MAP_GLYPH | 8'd6;
      16'hd0b8: v = MAP_GLYPH | 8'd7;
      16'hd0b9: v = MAP_GLYPH | 8'd8;
      16'hd0ba: v = "k";
      16'hd0bb: v = MAP_GLYPH | 8'd9;
      16'hd0bc: v = MAP_GLYPH | 8'd10;
      16'hd0bd: v = MAP_GLYPH | 8'd11;
      16'hd0be: v = "o";
      16'hd0bf: v = MAP_GLYPH | 8'd12;
      16'hd180: v = "p";
      16'hd181: v = "c";
      16'hd182: v = MAP_GLYPH | 8'd13;
      16'hd183: v = "y";
      16'hd184: v = MAP_GLYPH | 8'd14;
      16'hd185: v = "x";
      16'hd186: v = MAP_GLYPH | 8'd15;
      16'hd187: v = MAP_GLYPH | 8'd16;
      16'hd188: v = MAP_GLYPH | 8'd17;
      16'hd189: v = MAP_GLYPH | 8'd18;
      16'hd18a: v = MAP_GLYPH | 8'd19;
      16'hd18b: v = MAP_GLYPH | 8'd20;
      16'hd18c: v = MAP_GLYPH | 8'd21;
      16'hd18d: v = MAP_GLYPH | 8'd22;
      16'hd18e: v = MAP_GLYPH | 8'd23;
      16'hd18f: v = MAP_GLYPH | 8'd24;
      16'hd090: v = "A";
      16'hd091: v = MAP_GLYPH | 8'd25;
      16'hd092: v = "B";
      16'hd093: v = MAP_GLYPH | 8'd26;
      16'hd094: v = MAP_GLYPH | 8'd27;
      16'hd095: v = "E";
      16'hd081: v = MAP_GLYPH | 8'd28;
      16'hd096: v = MAP_GLYPH | 8'd29;
      16'hd097: v = MAP_GLYPH | 8'd30;
      16'hd098: v = MAP_GLYPH | 8'd31;
      16'hd099: v = MAP_GLYPH | 8'd32;
      16'hd09a: v = "K";
      16'hd09b: v = MAP_GLYPH | 8'd33;
      16'hd09c: v = "M";
      16'hd09d: v = "H";
      16'hd09e: v = "O";
      16'hd09f: v = MAP_GLYPH | 8'd34;
      16'hd0a0: v = "P";
      16'hd0a1: v = "C";
      16'hd0a2: v = "T";
      16'hd0a3: v = MAP_GLYPH | 8'd35;
      16'hd0a4: v = MAP_GLYPH | 8'd36;
      16'hd0a5: v = "X";
      16'hd0a6: v = MAP_GLYPH | 8'd37;
      16'hd0a7: v = MAP_GLYPH | 8'd38;
      16'hd0a8: v = MAP_GLYPH | 8'd39;
      16'hd0a9: v = MAP_GLYPH | 8'd40;
      16'hd0aa: v = MAP_GLYPH | 8'd41;
      16'hd0ab: v = MAP_GLYPH | 8'd42;
      16'hd0ac: v = MAP_GLYPH | 8'd43;
      16'hd0ad: v = MAP_GLYPH | 8'd44;
      16'hd0ae: v = MAP_GLYPH | 8'd45;
      16'hd0af: v = MAP_GLYPH | 8'd46;
      default:  v = MAP_UNKNOWN;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/cgsm_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cgsm_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] code_point;

  modport source (output valid, input ready, output opcode, output code_point);
  modport sink   (input valid, output ready, input opcode, input code_point);
endinterface
`default_nettype wire

/* design/cgsm_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cgsm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_custom;
  logic       load_glyph;
  logic [5:0] glyph_number;

  modport source (output valid, input ready, output char_code, output is_custom,
                  output load_glyph, output glyph_number);
  modport sink   (input valid, output ready, input char_code, input is_custom,
                  input load_glyph, input glyph_number);
endinterface
`default_nettype wire

/* design/cgsm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module cgsm_cell
  import cgsm_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               clear,
  input  wire logic               write_en,
  input  wire logic [GLYPH_W-1:0] glyph,
  input  wire cgsm_chain_t        chain_in,
  output      cgsm_chain_t        chain_out
);

  logic               valid;
  logic [GLYPH_W-1:0] held;
  logic               match;

  // Only a valid slot may claim the glyph; an unwritten entry is never compared
  assign match = valid && (held == glyph);

  // Pass an earlier claim through, else claim with this slot's number
  always_comb begin
    if (chain_in.hit) begin
      chain_out = chain_in;
    end else begin
      chain_out.hit  = match;
      chain_out.slot = SLOT_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (write_en) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      held <= glyph;
    end
  end

endmodule
`default_nettype wire

/* design/cyrillic_glyph_slot_mapper_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Cyrillic glyph slot mapper for a character display with custom glyph slots.
//
// in_ch  : opcode (map / flush) and a two-byte UTF-8 code, big-endian.
// out_ch : char_code, is_custom, load_glyph, glyph_number.
// Look-alike letters come out as their ASCII code. Every other letter is
// looked up in a row of SLOT_COUNT slot cells; a hit returns the slot number,
// a miss takes over the slot at the round-robin pointer and raises
// load_glyph so that the bitmap is written before the character is shown.
// Unknown codes and flushes give no result; a flush empties every slot and
// returns the pointer to slot 0.
//
// Timing: an item is taken, decoded into a holding register, and committed
// against the cell row once the output register has room; the result is then
// held in the output register. A new item is taken only once the held one is
// committed; unknown codes are dropped on the transfer and never held.
// When the receiver stalls, the result waits in the output register and the
// next item waits in the holding register; input ready drops until it moves.
// Synchronous reset empties every slot, zeroes the pointer and drops both
// valid flags; no clearing pass is needed afterwards.
module cyrillic_glyph_slot_mapper_top
  import cgsm_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cgsm_in_if.sink    in_ch,
  cgsm_out_if.source out_ch
);

  // Holding register between decode and commit
  logic       busy;
  logic [1:0] kind;
  logic [7:0] item_val;

  logic [SLOT_W-1:0] next_slot;

  logic [7:0] map_val;
  logic       accept;
  logic       commit;
  logic       is_glyph;
  logic       allocate;

  // Output register
  logic               out_valid;
  logic [7:0]         char_code;
  logic               is_custom;
  logic               load_glyph;
  logic [GLYPH_W-1:0] glyph_number;

  cgsm_chain_t chain [SLOT_COUNT+1];

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;
  assign map_val     = cgsm_decode(in_ch.code_point);

  // Commit once the output register is free or being drained; a flush needs
  // no room as it gives no result
  assign commit   = busy && ((kind == KIND_FLUSH) || !out_valid || out_ch.ready);
  assign is_glyph = (kind == KIND_GLYPH);
  assign allocate = commit && is_glyph && !chain[SLOT_COUNT].hit;

  // Take the item; drop unknown codes at once
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= (in_ch.opcode == OP_FLUSH) || (map_val != MAP_UNKNOWN);
    end else if (commit) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_val <= map_val;
      if (in_ch.opcode == OP_FLUSH) begin
        kind <= KIND_FLUSH;
      end else if ((map_val & MAP_GLYPH) != 8'd0) begin
        kind <= KIND_GLYPH;
      end else begin
        kind <= KIND_ASCII;
      end
    end
  end

  // Row of slot cells; the match token ripples from slot 0 upwards
  assign chain[0] = '0;

  genvar i;
  generate
    for (i = 0; i < SLOT_COUNT; i++) begin : g_cell
      cgsm_cell #(
        .INDEX(i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (commit && (kind == KIND_FLUSH)),
        .write_en (allocate && (next_slot == SLOT_W'(i))),
        .glyph    (item_val[GLYPH_W-1:0]),
        .chain_in (chain[i]),
        .chain_out(chain[i+1])
      );
    end
  endgenerate

  // Round-robin pointer: advance on a miss, wrap after the last slot, flush to 0
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot <= '0;
    end else if (commit && (kind == KIND_FLUSH)) begin
      next_slot <= '0;
    end else if (allocate) begin
      if (next_slot >= SLOT_W'(SLOT_COUNT - 1)) begin
        next_slot <= '0;
      end else begin
        next_slot <= next_slot + SLOT_W'(1);
      end
    end
  end

  // Load the output register on a non-flush commit, hold it until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && (kind != KIND_FLUSH)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && (kind != KIND_FLUSH)) begin
      if (is_glyph) begin
        // A miss reports the slot just taken over, the last slot included
        char_code    <= chain[SLOT_COUNT].hit ? 8'(chain[SLOT_COUNT].slot)
                                              : 8'(next_slot);
        is_custom    <= 1'b1;
        load_glyph   <= !chain[SLOT_COUNT].hit;
        glyph_number <= item_val[GLYPH_W-1:0];
      end else begin
        char_code    <= item_val;
        is_custom    <= 1'b0;
        load_glyph   <= 1'b0;
        glyph_number <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.char_code    = char_code;
  assign out_ch.is_custom    = is_custom;
  assign out_ch.load_glyph   = load_glyph;
  assign out_ch.glyph_number = glyph_number;

endmodule
`default_nettype wire

/* test/tb_cyrillic_glyph_slot_mapper_top.sv */
`timescale 1ns / 1ps
module tb_cyrillic_glyph_slot_mapper_top;
  import cgsm_pkg::*;

  localparam int unsigned SLOTS        = 8;
  localparam int          RANDOM_ITEMS = 1300;  // counted items: maps of known codes and flushes
  localparam int          LONG_HOLD    = 150;   // one long receiver stall, in cycles
  localparam int          HOLD_AFTER   = 300;   // results seen before that stall starts
  localparam int          QUIET_TAIL   = 120;   // pending items left when all idling stops
  localparam int          SETTLE       = 10;    // cycles to watch for stray results at the end
  localparam int          QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
  localparam int          CODE_TOTAL   = 66;
  localparam int          GLYPH_TOTAL  = 47;
  localparam logic [7:0]  NO_LOOKALIKE = 8'h00;

  // Known codes in table order, and the ASCII look-alike for each; letters without
  // one take glyph numbers 0..46 in the order they appear here.
  localparam logic [15:0] CYR_CODES [CODE_TOTAL] = '{
    16'hd0b0, 16'hd0b1, 16'hd0b2, 16'hd0b3, 16'hd0b4, 16'hd0b5, 16'hd191, 16'hd0b6,
    16'hd0b7, 16'hd0b8, 16'hd0b9, 16'hd0ba, 16'hd0bb, 16'hd0bc, 16'hd0bd, 16'hd0be,
    16'hd0bf, 16'hd180, 16'hd181, 16'hd182, 16'hd183, 16'hd184, 16'hd185, 16'hd186,
    16'hd187, 16'hd188, 16'hd189, 16'hd18a, 16'hd18b, 16'hd18c, 16'hd18d, 16'hd18e,
    16'hd18f, 16'hd090, 16'hd091, 16'hd092, 16'hd093, 16'hd094, 16'hd095, 16'hd081,
    16'hd096, 16'hd097, 16'hd098, 16'hd099, 16'hd09a, 16'hd09b, 16'hd09c, 16'hd09d,
    16'hd09e, 16'hd09f, 16'hd0a0, 16'hd0a1, 16'hd0a2, 16'hd0a3, 16'hd0a4, 16'hd0a5,
    16'hd0a6, 16'hd0a7, 16'hd0a8, 16'hd0a9, 16'hd0aa, 16'hd0ab, 16'hd0ac, 16'hd0ad,
    16'hd0ae, 16'hd0af
  };
  localparam logic [7:0] LOOKALIKES [CODE_TOTAL] = '{
    "a", 8'h00, 8'h00, 8'h00, 8'h00, "e", 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, "k", 8'h00, 8'h00, 8'h00, "o",
    8'h00, "p", "c", 8'h00, "y", 8'h00, "x", 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, "A", 8'h00, "B", 8'h00, 8'h00, "E", 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, "K", 8'h00, "M", "H",
    "O", 8'h00, "P", "C", "T", 8'h00, 8'h00, "X",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00
  };

  typedef struct {
    logic        opcode;
    logic [15:0] code_point;
    bit          drain_first;  // hold the transfer back until every result is in
  } glyph_req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_custom;
    logic       load_glyph;
    logic [5:0] glyph_number;
  } glyph_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cgsm_in_if  in_bus ();
  cgsm_out_if out_bus ();

  cyrillic_glyph_slot_mapper_top #(.SLOT_COUNT(SLOTS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Stimulus waiting to go out, and the results the slot table says must come back
  glyph_req_t  pending_reqs [$];
  glyph_res_t  expected_glyphs [$];
  logic [15:0] glyph_codes [GLYPH_TOTAL];

  // Shadow of the slot table
  logic [5:0]  shadow_glyph [SLOTS];
  bit          shadow_used [SLOTS];
  int unsigned shadow_ptr;

  int fail_count;
  int sent_count, results_seen;
  int map_count, flush_count, unknown_count, lookalike_count, hit_count, load_count;
  int long_hold_left;
  bit long_hold_done;

  // Find a code in the table; give back its look-alike (or none) and its glyph number
  function automatic bit find_code(input logic [15:0] cp, output logic [7:0] ascii,
                                   output logic [5:0] glyph);
    int n;
    n     = 0;
    ascii = NO_LOOKALIKE;
    glyph = '0;
    for (int i = 0; i < CODE_TOTAL; i++) begin
      if (CYR_CODES[i] == cp) begin
        ascii = LOOKALIKES[i];
        glyph = n[5:0];
        return 1'b1;
      end
      if (LOOKALIKES[i] == NO_LOOKALIKE) n++;
    end
    return 1'b0;
  endfunction

  // Advance the shadow table by one accepted transfer and queue its result, if any
  task automatic predict_slot_lookup(input glyph_req_t req);
    logic [7:0] ascii;
    logic [5:0] glyph;
    glyph_res_t res;
    int         slot;
    sent_count++;
    if (req.opcode == OP_FLUSH) begin
      for (int s = 0; s < SLOTS; s++) begin
        shadow_used[s]  = 1'b0;
        shadow_glyph[s] = '0;
      end
      shadow_ptr = 0;
      flush_count++;
    end else if (!find_code(req.code_point, ascii, glyph)) begin
      unknown_count++;
    end else begin
      map_count++;
      if (ascii != NO_LOOKALIKE) begin
        res = '{ascii, 1'b0, 1'b0, 6'd0};
        lookalike_count++;
      end else begin
        slot = -1;
        for (int s = 0; s < SLOTS; s++)
          if (slot < 0 && shadow_used[s] && shadow_glyph[s] == glyph) slot = s;
        res.load_glyph = (slot < 0);
        if (slot < 0) begin
          // miss: take over the slot under the pointer, then step it round
          slot               = shadow_ptr;
          shadow_glyph[slot] = glyph;
          shadow_used[slot]  = 1'b1;
          shadow_ptr         = (shadow_ptr == SLOTS - 1) ? 0 : shadow_ptr + 1;
          load_count++;
        end else begin
          hit_count++;
        end
        res.char_code    = 8'(slot);
        res.is_custom    = 1'b1;
        res.glyph_number = glyph;
      end
      expected_glyphs.push_back(res);
    end
  endtask

  task automatic note_mismatch(input string what, input glyph_res_t want, input glyph_res_t got);
    fail_count++;
    if (fail_count <= 10)
      $display({"%0t: %s: expected char=%h custom=%b load=%b glyph=%0d, ",
                "got char=%h custom=%b load=%b glyph=%0d"},
               $realtime, what, want.char_code, want.is_custom, want.load_glyph,
               want.glyph_number, got.char_code, got.is_custom, got.load_glyph,
               got.glyph_number);
  endtask

  task automatic queue_req(input logic op, input logic [15:0] cp, input bit drain);
    glyph_req_t req;
    req.opcode      = op;
    req.code_point  = cp;
    req.drain_first = drain;
    pending_reqs.push_back(req);
  endtask

  // Sender: offer the next pending item, hold it until the transfer, and insert
  // random gaps between items; no gaps during the long receiver stall or the tail.
  glyph_req_t on_offer;
  int         send_gap;

  always @(posedge clk) begin : drive_requests
    logic next_valid;
    int   idle_pct;
    if (rst) begin
      in_bus.valid      <= 1'b0;
      in_bus.opcode     <= OP_MAP;
      in_bus.code_point <= '0;
      send_gap = 0;
    end else begin
      next_valid = in_bus.valid;
      case ((sent_count / 170) % 3)
        0:       idle_pct = 20;
        1:       idle_pct = 0;
        default: idle_pct = 45;
      endcase
      if (pending_reqs.size() < QUIET_TAIL || long_hold_left > 0) idle_pct = 0;
      if (in_bus.valid && in_bus.ready) begin
        predict_slot_lookup(on_offer);
        next_valid = 1'b0;
        if ($urandom_range(99, 0) < idle_pct) send_gap = $urandom_range(7, 1);
      end else if (!next_valid && send_gap > 0) begin
        send_gap--;
      end
      // Load the next item unless a gap is running or it must wait for the results to drain
      if (!next_valid && send_gap == 0 && pending_reqs.size() > 0 &&
          !(pending_reqs[0].drain_first && expected_glyphs.size() > 0)) begin
        on_offer          = pending_reqs.pop_front();
        in_bus.opcode     <= on_offer.opcode;
        in_bus.code_point <= on_offer.code_point;
        next_valid = 1'b1;
      end
      in_bus.valid <= next_valid;
    end
  end

  // Receiver: check every result transfer against the oldest expectation, stall at random,
  // and once in the run hold off long enough for the block to back up into its input.
  int take_gap;

  always @(posedge clk) begin : watch_results
    glyph_res_t got;
    int         stall_pct;
    if (rst) begin
      out_bus.ready <= 1'b0;
      take_gap       = 0;
      long_hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.char_code, out_bus.is_custom, out_bus.load_glyph, out_bus.glyph_number};
        results_seen++;
        if (expected_glyphs.size() == 0) begin
          note_mismatch("unexpected result", '{8'h00, 1'b0, 1'b0, 6'd0}, got);
        end else if (expected_glyphs[0] !== got) begin
          note_mismatch("result mismatch", expected_glyphs[0], got);
          void'(expected_glyphs.pop_front());
        end else begin
          void'(expected_glyphs.pop_front());
        end
      end
      case ((results_seen / 150) % 3)
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        default: stall_pct = 50;
      endcase
      if (pending_reqs.size() < QUIET_TAIL) stall_pct = 0;
      if (long_hold_left > 0) begin
        long_hold_left--;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (take_gap > 0) begin
        take_gap--;
      end else if ($urandom_range(99, 0) < stall_pct) begin
        take_gap = $urandom_range(7, 1);
      end
      out_bus.ready <= (long_hold_left == 0 && take_gap == 0);
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, expected_glyphs.size());
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int          work_items, pick, pool, base, n, g;
    logic [15:0] cp;
    logic [7:0]  ascii;
    logic [5:0]  glyph;

    in_bus.valid      = 1'b0;
    in_bus.opcode     = OP_MAP;
    in_bus.code_point = '0;
    out_bus.ready     = 1'b0;
    fail_count = 0;
    sent_count = 0;
    results_seen = 0;
    map_count = 0;
    flush_count = 0;
    unknown_count = 0;
    lookalike_count = 0;
    hit_count = 0;
    load_count = 0;
    shadow_ptr = 0;
    for (int s = 0; s < SLOTS; s++) begin
      shadow_used[s]  = 1'b0;
      shadow_glyph[s] = '0;
    end

    // Collect the code of each glyph number for quick picking
    n = 0;
    for (int i = 0; i < CODE_TOTAL; i++)
      if (LOOKALIKES[i] == NO_LOOKALIKE) begin
        glyph_codes[n] = CYR_CODES[i];
        n++;
      end

    // Directed part: flush with every code bit set, codes at the ends of the range,
    // look-alikes, nine fresh glyphs so the pointer wraps past the last slot, hits on
    // the first and last slot, an evicted glyph, a flush after draining, then the
    // last table entry, codes d18f, d081 and d191, and a hit on slot 0 after it.
    queue_req(OP_FLUSH, 16'hffff, 1'b0);
    queue_req(OP_MAP, 16'h0000, 1'b0);
    queue_req(OP_MAP, 16'hffff, 1'b0);
    queue_req(OP_MAP, 16'hd0b0, 1'b0);
    queue_req(OP_MAP, 16'hd090, 1'b0);
    for (int k = 0; k < 9; k++) queue_req(OP_MAP, glyph_codes[k], 1'b0);
    queue_req(OP_MAP, glyph_codes[8], 1'b0);
    queue_req(OP_MAP, glyph_codes[7], 1'b0);
    queue_req(OP_MAP, 16'hd0b1, 1'b0);
    queue_req(OP_FLUSH, 16'hd0b1, 1'b1);
    queue_req(OP_MAP, 16'hd0af, 1'b0);
    queue_req(OP_MAP, 16'hd18f, 1'b0);
    queue_req(OP_MAP, 16'hd081, 1'b0);
    queue_req(OP_MAP, 16'hd191, 1'b0);
    queue_req(OP_MAP, 16'hd0af, 1'b0);

    // Random part: mostly glyphs from a shifting working set, so hits, misses and
    // evictions all happen; some look-alikes, a few flushes and unknown codes.
    work_items = 0;
    pool = 6;
    base = 0;
    while (work_items < RANDOM_ITEMS) begin
      if ($urandom_range(49, 0) == 0) begin
        pool = $urandom_range(14, 3);
        base = $urandom_range(GLYPH_TOTAL - pool, 0);
      end
      pick = $urandom_range(99, 0);
      if (pick < 3) begin
        queue_req(OP_FLUSH, 16'($urandom), $urandom_range(3, 0) == 0);
        work_items++;
      end else if (pick < 10) begin
        // unknown code: anything at all, or a near miss in the Cyrillic lead bytes
        do begin
          if ($urandom_range(1, 0) == 1)
            cp = 16'($urandom);
          else
            cp = {7'b1101000, 1'($urandom_range(1, 0)), 8'($urandom)};
        end while (find_code(cp, ascii, glyph));
        queue_req(OP_MAP, cp, 1'b0);
      end else if (pick < 28) begin
        do n = $urandom_range(CODE_TOTAL - 1, 0);
        while (LOOKALIKES[n] == NO_LOOKALIKE);
        queue_req(OP_MAP, CYR_CODES[n], 1'b0);
        work_items++;
      end else begin
        if ($urandom_range(9, 0) == 0)
          g = $urandom_range(GLYPH_TOTAL - 1, 0);
        else
          g = base + $urandom_range(pool - 1, 0);
        queue_req(OP_MAP, glyph_codes[g], $urandom_range(99, 0) == 0);
        work_items++;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Drain: all items out, every expected result in, then a few quiet cycles
    while (pending_reqs.size() != 0 || in_bus.valid) @(posedge clk);
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d transfers: %0d known codes, %0d flushes, %0d unknown codes",
             sent_count, map_count, flush_count, unknown_count);
    $display("checked %0d results: %0d look-alikes, %0d slot hits, %0d glyph loads, %0d mismatches",
             results_seen, lookalike_count, hit_count, load_count, fail_count);
    if (fail_count == 0 && expected_glyphs.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* cyrillic_glyph_slot_mapper_top.f */
design/cgsm_pkg.sv
design/cgsm_in_if.sv
design/cgsm_out_if.sv
design/cgsm_cell.sv
design/cyrillic_glyph_slot_mapper_top.sv
test/tb_cyrillic_glyph_slot_mapper_top.sv
